@@ src/dat_pkg.sv @@
// ----------------------------------------------------------------------------
// device address table package
// Shared transaction types, request and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package dat_pkg;

	// request kinds
	localparam logic [1:0] KIND_UPSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	// result status codes
	localparam logic [2:0] STATUS_ADDED     = 3'd0;
	localparam logic [2:0] STATUS_UPDATED   = 3'd1;
	localparam logic [2:0] STATUS_FULL      = 3'd2;
	localparam logic [2:0] STATUS_FOUND     = 3'd3;
	localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;
	localparam logic [2:0] STATUS_DELETED   = 3'd5;

	// field widths
	localparam int KEY_W   = 16;
	localparam int VALUE_W = 64;
	localparam int POS_W   = 6;
	localparam int TOTAL_W = 7;
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// request transaction
	typedef struct packed {
		logic [1:0]         kind;
		logic [KEY_W-1:0]   short_address;
		logic [VALUE_W-1:0] long_address;
	} req_t;

	// result transaction
	typedef struct packed {
		logic [2:0]         status;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] found_value;
		logic [TOTAL_W-1:0] entry_total;
	} rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

@@ src/dat_ram.sv @@
// ----------------------------------------------------------------------------
// dat_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/device_address_table.sv @@
// ----------------------------------------------------------------------------
// device_address_table
// Ordered short/long address table with linear search and delete compaction.
// ----------------------------------------------------------------------------
// operation: lookup and upsert scan the table RAM one entry per cycle, stopping
//   at the first match, and a miss reads every entry below the count; a delete
//   then moves each later entry down one place. One request at a time; the next
//   is taken the cycle after the result is registered
// reset: entry count cleared, limit set to 64; table RAM contents are not
//   cleared since only entries below the count are ever read
module device_address_table
	import dat_pkg::*;
#(
	parameter int MAX_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               cfg_write_en,
	input  logic [LIMIT_W-1:0] cfg_write_data
);

	localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int PXW = AW + POS_W;
	localparam int TXW = CW + TOTAL_W;
	localparam int EW  = KEY_W + VALUE_W;

	state_t state_q, state_d;

	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      scan_idx_q;
	req_t               req_q;
	logic               hit_q;
	logic [AW-1:0]      hit_idx_q;
	logic [VALUE_W-1:0] hit_val_q;
	logic [2:0]         res_status_q;
	logic [AW-1:0]      res_pos_q;
	logic               res_pos_en_q;
	logic [VALUE_W-1:0] res_val_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               rd_v_s1;
	logic [AW-1:0]      rd_idx_s1;

	// ram ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	// control strobes from the sequencer
	logic req_take, scan_step, scan_end, count_inc, count_dec, res_load, rsp_load;
	logic [2:0] res_status_d;
	logic       res_pos_en_d;
	logic [AW-1:0] res_pos_d;
	logic [VALUE_W-1:0] res_val_d;
	logic key_match, full;

	// output field masking
	logic [PXW-1:0] pos_wide;
	logic [TXW-1:0] total_wide;
	assign pos_wide   = PXW'(res_pos_q);
	assign total_wide = TXW'(count_q);

	// effective limit and fill check
	logic [LW-1:0] limit_eff;
	always_comb begin
		limit_eff = (LW'(limit_q) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(limit_q);
	end
	assign full = LW'(count_q) >= limit_eff;

	assign key_match = rd_v_s1 && (ram_rdata[EW-1 -: KEY_W] == req_q.short_address);

	// next state and datapath control
	always_comb begin
		state_d      = state_q;
		req_take     = 1'b0;
		scan_step    = 1'b0;
		scan_end     = 1'b0;
		count_inc    = 1'b0;
		count_dec    = 1'b0;
		res_load     = 1'b0;
		rsp_load     = 1'b0;
		res_status_d = STATUS_NOT_FOUND;
		res_pos_en_d = 1'b0;
		res_pos_d    = hit_idx_q;
		res_val_d    = '0;
		ram_we       = 1'b0;
		ram_waddr    = hit_idx_q;
		ram_wdata    = {req_q.short_address, req_q.long_address};
		ram_re       = 1'b0;
		ram_raddr    = scan_idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_take = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (key_match) begin
					scan_end = 1'b1;
					state_d  = ST_ACT;
				end else if (scan_idx_q < count_q) begin
					ram_re    = 1'b1;
					scan_step = 1'b1;
				end else if (!rd_v_s1) begin
					scan_end = 1'b1;
					state_d  = ST_ACT;
				end
			end
			ST_ACT: begin
				res_load = 1'b1;
				state_d  = ST_DONE;
				case (req_q.kind)
					KIND_UPSERT: begin
						if (hit_q) begin
							ram_we       = 1'b1;
							res_status_d = STATUS_UPDATED;
							res_pos_en_d = 1'b1;
						end else if (full) begin
							res_status_d = STATUS_FULL;
						end else begin
							ram_we       = 1'b1;
							ram_waddr    = count_q[AW-1:0];
							count_inc    = 1'b1;
							res_status_d = STATUS_ADDED;
							res_pos_en_d = 1'b1;
							res_pos_d    = count_q[AW-1:0];
						end
					end
					KIND_LOOKUP: begin
						if (hit_q) begin
							res_status_d = STATUS_FOUND;
							res_pos_en_d = 1'b1;
							res_val_d    = hit_val_q;
						end
					end
					KIND_DELETE: begin
						if (hit_q) begin
							res_status_d = STATUS_DELETED;
							res_pos_en_d = 1'b1;
							res_val_d    = hit_val_q;
							state_d      = ST_SHIFT;
						end
					end
					default: begin
						res_status_d = STATUS_NOT_FOUND;
					end
				endcase
			end
			ST_SHIFT: begin
				// read entry j, write it back at j - 1 in the following cycle
				ram_raddr = scan_idx_q[AW-1:0];
				ram_waddr = rd_idx_s1 - AW'(1);
				ram_wdata = ram_rdata;
				ram_we    = rd_v_s1;
				if (scan_idx_q < count_q) begin
					ram_re    = 1'b1;
					scan_step = 1'b1;
				end else if (!rd_v_s1) begin
					count_dec = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			rd_v_s1     <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				limit_q <= cfg_write_data;
			end
			if (count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (count_dec) begin
				count_q <= count_q - CW'(1);
			end
			rd_v_s1 <= ram_re;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
		if (req_take) begin
			req_q      <= req;
			scan_idx_q <= '0;
		end else if (scan_step) begin
			scan_idx_q <= scan_idx_q + CW'(1);
		end else if (res_load) begin
			// shift starts with the entry after the deleted one
			scan_idx_q <= CW'(hit_idx_q) + CW'(1);
		end
		if (scan_end) begin
			hit_q     <= key_match;
			hit_idx_q <= rd_idx_s1;
			hit_val_q <= ram_rdata[VALUE_W-1:0];
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_pos_en_q <= res_pos_en_d;
			res_pos_q    <= res_pos_d;
			res_val_q    <= res_val_d;
		end
		if (rsp_load) begin
			rsp_q.status      <= res_status_q;
			rsp_q.position    <= res_pos_en_q ? pos_wide[POS_W-1:0] : '0;
			rsp_q.found_value <= res_val_q;
			rsp_q.entry_total <= total_wide[TOTAL_W-1:0];
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// entry table: key over value
	dat_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

@@ sim/table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device address table checker
// Watches the request, result and limit ports of the table. It keeps its own
// copy of the ordered key/value table, works out the reply that each accepted
// request owes, and compares every accepted result with the oldest owed reply.
// ----------------------------------------------------------------------------
module table_checker
	import dat_pkg::*;
#(
	parameter int MAX_ENTRIES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  req_t               req,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  rsp_t               rsp,
	input  logic               cfg_write_en,
	input  logic [LIMIT_W-1:0] cfg_write_data,
	output int                 owed_count,
	output int                 mismatch_count,
	output int                 replies_checked
);

	// shadow copy of the table and its limit
	logic [KEY_W-1:0]   key_table [MAX_ENTRIES];
	logic [VALUE_W-1:0] value_table [MAX_ENTRIES];
	int                 entries = 0;
	logic [LIMIT_W-1:0] entry_limit = LIMIT_RESET;
	rsp_t               owed_replies [$];

	// apply one request to the shadow table and build the reply it owes
	function automatic rsp_t serve_request(input req_t r);
		rsp_t reply;
		int   hit;
		int   cap;
		int   i;
		reply = '0;
		reply.status = STATUS_NOT_FOUND;
		cap = (int'(entry_limit) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_limit);
		// first matching entry, or entries when there is none
		hit = entries;
		for (i = 0; i < entries; i++)
			if (hit == entries && key_table[i] == r.short_address)
				hit = i;
		case (r.kind)
			KIND_UPSERT: begin
				if (hit < entries) begin
					value_table[hit] = r.long_address;
					reply.status = STATUS_UPDATED;
					reply.position = hit[POS_W-1:0];
				end else if (entries >= cap) begin
					reply.status = STATUS_FULL;
				end else begin
					key_table[entries] = r.short_address;
					value_table[entries] = r.long_address;
					reply.status = STATUS_ADDED;
					reply.position = entries[POS_W-1:0];
					entries++;
				end
			end
			KIND_LOOKUP: begin
				if (hit < entries) begin
					reply.status = STATUS_FOUND;
					reply.position = hit[POS_W-1:0];
					reply.found_value = value_table[hit];
				end
			end
			KIND_DELETE: begin
				if (hit < entries) begin
					reply.status = STATUS_DELETED;
					reply.position = hit[POS_W-1:0];
					reply.found_value = value_table[hit];
					// close the gap, keeping the order
					for (i = hit; i + 1 < entries; i++) begin
						key_table[i] = key_table[i + 1];
						value_table[i] = value_table[i + 1];
					end
					entries--;
				end
			end
			default: ;
		endcase
		reply.entry_total = entries[TOTAL_W-1:0];
		return reply;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// compare results, follow limit writes, record owed replies
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			entries = 0;
			entry_limit = LIMIT_RESET;
			owed_replies.delete();
			mismatch_count = 0;
			replies_checked = 0;
			owed_count <= 0;
		end else begin
			// result transaction against the oldest owed reply
			if (rsp_valid && !rsp_stall) begin
				if (owed_replies.size() == 0) begin
					report_mismatch("result with no request waiting", 64'(rsp.status), '0);
				end else begin
					want = owed_replies.pop_front();
					replies_checked++;
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.position !== want.position)
						report_mismatch("position", 64'(rsp.position),
							64'(want.position));
					if (rsp.found_value !== want.found_value)
						report_mismatch("found_value", rsp.found_value, want.found_value);
					if (rsp.entry_total !== want.entry_total)
						report_mismatch("entry_total", 64'(rsp.entry_total),
							64'(want.entry_total));
				end
			end
			if (cfg_write_en)
				entry_limit = cfg_write_data;
			// request transaction
			if (req_valid && !req_stall)
				owed_replies.push_back(serve_request(req));
			owed_count <= owed_replies.size();
		end
	end

endmodule

@@ sim/tb_device_address_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device address table testbench
// Drives upsert, lookup, delete and unused requests into the table under a
// series of entry limits, with random gaps on the request side and random
// stalls on the result side. The checker beside the block does the checking;
// this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_device_address_table;
	import dat_pkg::*;

	localparam int MAX_ENTRIES    = 64;
	localparam int TARGET_ITEMS   = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 2 * MAX_ENTRIES + 8;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [15:0] POOL_BASE = 16'h8000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_t               rsp;
	logic               cfg_write_en = 1'b0;
	logic [LIMIT_W-1:0] cfg_write_data = '0;

	int owed_count;
	int mismatch_count;
	int replies_checked;
	int items_sent = 0;
	int limits_written = 0;
	int quiet_cycles = 0;
	int stall_hold = 0;
	bit sender_bursting = 1'b0;

	always #1 clk = ~clk;

	device_address_table #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	table_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.owed_count     (owed_count),
		.mismatch_count (mismatch_count),
		.replies_checked(replies_checked)
	);

	// result side stalls: short bursts, a few long ones, some long clear stretches
	always @(posedge clk) begin
		int pick;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				rsp_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 8);
			end else if (pick < 90) begin
				rsp_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 3);
			end else if (pick < 97) begin
				rsp_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end else begin
				rsp_stall <= 1'b0;
				stall_hold <= $urandom_range(50, 150);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic req_t make_request(input logic [1:0] kind, input logic [15:0] key,
			input logic [63:0] value);
		req_t r;
		r.kind = kind;
		r.short_address = key;
		r.long_address = value;
		return r;
	endfunction

	// mostly keys from a small pool so that hits are common
	function automatic req_t random_request();
		int             pick;
		logic [1:0]     kind;
		logic [15:0]    key;
		logic [63:0]    value;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			kind = KIND_UPSERT;
		else if (pick < 70)
			kind = KIND_LOOKUP;
		else if (pick < 95)
			kind = KIND_DELETE;
		else
			kind = KIND_UNUSED;
		if ($urandom_range(0, 99) < 85)
			key = POOL_BASE + 16'($urandom_range(0, 79));
		else
			key = 16'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			value = '0;
		else if (pick == 1)
			value = ALL_ONES;
		else
			value = {$urandom, $urandom};
		return make_request(kind, key, value);
	endfunction

	// hand one request transaction to the block, after a random gap
	task automatic send_request(input req_t r);
		int pick;
		int gap;
		pick = $urandom_range(0, 99);
		if (sender_bursting || pick < 60)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && !req_stall));
		items_sent++;
	endtask

	// stop sending until every owed reply has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		cfg_write_data <= value;
		cfg_write_en <= 1'b1;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		limits_written++;
	endtask

	initial begin
		int          phase;
		int          count;
		logic [6:0]  next_limit;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, key and value extremes, update, unused kind
		send_request(make_request(KIND_LOOKUP, 16'h0000, '0));
		send_request(make_request(KIND_DELETE, 16'h0000, '0));
		send_request(make_request(KIND_UPSERT, 16'h0000, '0));
		send_request(make_request(KIND_UPSERT, 16'hFFFF, ALL_ONES));
		send_request(make_request(KIND_UPSERT, 16'h0000, 64'hA5A5_5A5A_0F0F_F0F0));
		send_request(make_request(KIND_LOOKUP, 16'hFFFF, '0));
		send_request(make_request(KIND_UNUSED, 16'hFFFF, ALL_ONES));
		send_request(make_request(KIND_UPSERT, 16'h1234, 64'h0123_4567_89AB_CDEF));
		send_request(make_request(KIND_DELETE, 16'h0000, ALL_ONES));
		send_request(make_request(KIND_LOOKUP, 16'h1234, '0));

		// limit zero, below the count: misses are full, hits still work
		wait_drained();
		write_limit(7'd0);
		send_request(make_request(KIND_UPSERT, 16'h5555, 64'h5555_5555_5555_5555));
		send_request(make_request(KIND_UPSERT, 16'hFFFF, 64'hFEDC_BA98_7654_3210));
		send_request(make_request(KIND_LOOKUP, 16'h1234, '0));
		send_request(make_request(KIND_DELETE, 16'h1234, '0));

		// limit above the table size: fill the table and run past its end
		wait_drained();
		write_limit(7'd127);
		for (int i = 0; i < 70; i++)
			send_request(make_request(KIND_UPSERT, POOL_BASE + 16'(i), {$urandom, $urandom}));
		repeat (40) send_request(random_request());

		// random phases under a series of limits
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			wait_drained();
			case (phase)
				0: next_limit = 7'd3;
				1: next_limit = 7'd0;
				2: next_limit = 7'd64;
				3: next_limit = 7'd1;
				4: next_limit = 7'd100;
				5: next_limit = 7'd65;
				6: next_limit = 7'd2;
				default: next_limit = 7'($urandom_range(0, 127));
			endcase
			write_limit(next_limit);
			sender_bursting = (phase % 3 == 2);
			count = $urandom_range(25, 50);
			repeat (count) begin
				if ($urandom_range(0, 49) == 0)
					wait_drained();
				send_request(random_request());
			end
			phase++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run: %0d requests, %0d results checked, %0d limit settings",
			items_sent, replies_checked, limits_written);
		$display("covered: full table under an oversized limit, zero and lowered limits, "
			, "delete compaction, unused request kind");
		if (mismatch_count == 0 && owed_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
